/* rtl/ddu_pkg.sv */
// shared types, widths and the month table for the date difference unit
`default_nettype none

package ddu_pkg;

  localparam int unsigned DAY_W       = 5;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned YEAR_W      = 12;
  localparam int unsigned ORDER_W     = 2;
  localparam int unsigned DAY_GAP_W   = 17;
  localparam int unsigned MONTH_GAP_W = 12;
  localparam int unsigned YEAR_GAP_W  = 9;

  // serial day number: 365*4095 plus leap days plus a year of months plus day
  localparam int unsigned SERIAL_W    = 21;
  // year*12 + month
  localparam int unsigned MONTH_NUM_W = 16;
  // days before the first of a month fit in 9 bits
  localparam int unsigned DBM_W       = 9;

  typedef enum logic [ORDER_W-1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_EARLIER = 2'd1,
    ORD_LATER   = 2'd2
  } order_e;

  typedef logic [DBM_W-1:0] dbm_t;

  // days before the first of each month code, codes above twelve count a full year
  function automatic dbm_t days_before(input logic [MONTH_W-1:0] month);
    dbm_t res;
    case (month)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd59;
      4'd4:    res = 9'd90;
      4'd5:    res = 9'd120;
      4'd6:    res = 9'd151;
      4'd7:    res = 9'd181;
      4'd8:    res = 9'd212;
      4'd9:    res = 9'd243;
      4'd10:   res = 9'd273;
      4'd11:   res = 9'd304;
      4'd12:   res = 9'd334;
      default: res = 9'd365;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/ddu_if.sv */
// valid/ready channels carrying a date pair and the resulting gaps
`default_nettype none

interface ddu_in_if;
  import ddu_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   first_day;
  logic [MONTH_W-1:0] first_month;
  logic [YEAR_W-1:0]  first_year;
  logic [DAY_W-1:0]   second_day;
  logic [MONTH_W-1:0] second_month;
  logic [YEAR_W-1:0]  second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

interface ddu_out_if;
  import ddu_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ORDER_W-1:0]     order;
  logic [DAY_GAP_W-1:0]   day_gap;
  logic [MONTH_GAP_W-1:0] month_gap;
  logic [YEAR_GAP_W-1:0]  year_gap;

  modport source (
    output valid, order, day_gap, month_gap, year_gap,
    input  ready
  );

  modport sink (
    input  valid, order, day_gap, month_gap, year_gap,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/ddu_serial.sv */
// converts one date to a serial day number
`default_nettype none

module ddu_serial (
  input  logic [ddu_pkg::DAY_W-1:0]    day_i,
  input  logic [ddu_pkg::MONTH_W-1:0]  month_i,
  input  logic [ddu_pkg::YEAR_W-1:0]   year_i,
  output logic [ddu_pkg::SERIAL_W-1:0] serial_o
);
  import ddu_pkg::*;

  // floor(x/100) as (x*5243) >> 19, exact for x below 4096
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SH  = 19;

  logic [YEAR_W-1:0]   leap_year;
  logic [YEAR_W-3:0]   q4;
  logic [24:0]         prod100;
  logic [22:0]         prod400;
  logic [5:0]          q100;
  logic [3:0]          q400;
  logic [YEAR_W-3:0]   leap_days;
  logic [SERIAL_W-1:0] year_days;

  always_comb begin
    // january and february count leap days up to the year before
    if (month_i <= 4'd2 && year_i != '0) begin
      leap_year = year_i - 12'd1;
    end else begin
      leap_year = year_i;
    end
    q4        = leap_year[YEAR_W-1:2];
    prod100   = {13'd0, leap_year} * {12'd0, RECIP_100};
    prod400   = {13'd0, q4} * {10'd0, RECIP_100};
    q100      = prod100[RECIP_SH +: 6];
    q400      = prod400[RECIP_SH +: 4];
    leap_days = q4 - {4'd0, q100} + {6'd0, q400};
    year_days = {9'd0, year_i} * 21'd365;
    serial_o  = year_days + {11'd0, leap_days}
              + {12'd0, days_before(month_i)} + {16'd0, day_i};
  end

endmodule

`default_nettype wire

/* rtl/date_difference_unit.sv */
// Date difference unit: takes a pair of Gregorian dates per transfer and returns their
// order and the absolute gaps in days, months and years (gaps saturate at their field
// width). Dates are not checked. Two register stages: the input register and the result
// register, with one pass of conversion and subtract logic between them. A pair can be
// taken every cycle while the output is not stalled, and while the output is stalled the input
// register still takes one more pair.
`default_nettype none

module date_difference_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddu_in_if.sink     dates_i,
  ddu_out_if.source  gaps_o
);
  import ddu_pkg::*;

  localparam logic [DAY_GAP_W-1:0]   DAY_GAP_MAX   = '1;
  localparam logic [MONTH_GAP_W-1:0] MONTH_GAP_MAX = '1;
  localparam logic [YEAR_GAP_W-1:0]  YEAR_GAP_MAX  = '1;

  // input register
  logic               in_valid_q;
  logic [DAY_W-1:0]   d1_q, d2_q;
  logic [MONTH_W-1:0] m1_q, m2_q;
  logic [YEAR_W-1:0]  y1_q, y2_q;

  // result register
  logic                   out_valid_q;
  order_e                 order_q, order_d;
  logic [DAY_GAP_W-1:0]   day_gap_q, day_gap_d;
  logic [MONTH_GAP_W-1:0] month_gap_q, month_gap_d;
  logic [YEAR_GAP_W-1:0]  year_gap_q, year_gap_d;

  logic in_xfer, out_load, stage_move;

  logic [SERIAL_W-1:0]    ser1, ser2, ser_diff;
  logic [MONTH_NUM_W-1:0] mnum1, mnum2, mnum_diff;
  logic [YEAR_W-1:0]      year_diff;

  assign out_load      = !out_valid_q || gaps_o.ready;
  assign stage_move    = in_valid_q && out_load;
  assign dates_i.ready = !in_valid_q || out_load;
  assign in_xfer       = dates_i.valid && dates_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (dates_i.ready) begin
        in_valid_q <= dates_i.valid;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      d1_q <= dates_i.first_day;
      m1_q <= dates_i.first_month;
      y1_q <= dates_i.first_year;
      d2_q <= dates_i.second_day;
      m2_q <= dates_i.second_month;
      y2_q <= dates_i.second_year;
    end
    if (stage_move) begin
      order_q     <= order_d;
      day_gap_q   <= day_gap_d;
      month_gap_q <= month_gap_d;
      year_gap_q  <= year_gap_d;
    end
  end

  ddu_serial u_serial_first (
    .day_i    (d1_q),
    .month_i  (m1_q),
    .year_i   (y1_q),
    .serial_o (ser1)
  );

  ddu_serial u_serial_second (
    .day_i    (d2_q),
    .month_i  (m2_q),
    .year_i   (y2_q),
    .serial_o (ser2)
  );

  always_comb begin
    if (y1_q != y2_q) begin
      order_d = (y1_q < y2_q) ? ORD_EARLIER : ORD_LATER;
    end else if (m1_q != m2_q) begin
      order_d = (m1_q < m2_q) ? ORD_EARLIER : ORD_LATER;
    end else if (d1_q != d2_q) begin
      order_d = (d1_q < d2_q) ? ORD_EARLIER : ORD_LATER;
    end else begin
      order_d = ORD_EQUAL;
    end

    ser_diff  = (ser1 > ser2) ? (ser1 - ser2) : (ser2 - ser1);
    mnum1     = {4'd0, y1_q} * 16'd12 + {12'd0, m1_q};
    mnum2     = {4'd0, y2_q} * 16'd12 + {12'd0, m2_q};
    mnum_diff = (mnum1 > mnum2) ? (mnum1 - mnum2) : (mnum2 - mnum1);
    year_diff = (y1_q > y2_q) ? (y1_q - y2_q) : (y2_q - y1_q);

    // saturate each gap at its field width
    day_gap_d   = (ser_diff > {4'd0, DAY_GAP_MAX}) ? DAY_GAP_MAX
                                                   : ser_diff[DAY_GAP_W-1:0];
    month_gap_d = (mnum_diff > {4'd0, MONTH_GAP_MAX}) ? MONTH_GAP_MAX
                                                      : mnum_diff[MONTH_GAP_W-1:0];
    year_gap_d  = (year_diff > {3'd0, YEAR_GAP_MAX}) ? YEAR_GAP_MAX
                                                     : year_diff[YEAR_GAP_W-1:0];
  end

  assign gaps_o.valid     = out_valid_q;
  assign gaps_o.order     = order_q;
  assign gaps_o.day_gap   = day_gap_q;
  assign gaps_o.month_gap = month_gap_q;
  assign gaps_o.year_gap  = year_gap_q;

  // an accepted pair sits in the input register on the next cycle
  a_in_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_valid_q)
    else $error("accepted pair missing from input register");

  // a pair held back by a stalled output is not dropped
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_load |=> in_valid_q)
    else $error("stalled pair lost from input register");

  // equal dates give zero gaps
  a_equal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && order_q == ORD_EQUAL |->
      day_gap_q == '0 && month_gap_q == '0 && year_gap_q == '0)
    else $error("equal dates with nonzero gap");

  // differing years cannot report equal dates
  a_year_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && year_gap_q != '0 |-> order_q != ORD_EQUAL)
    else $error("year gap inconsistent with order");

endmodule

`default_nettype wire
